/* rtl/swam_pkg.sv */
// ----------------------------------------------------------------------------
// swam_pkg
// Shared types and constants for the sliding window anagram matcher.
// ----------------------------------------------------------------------------
package swam_pkg;

    localparam int MAX_PAT  = 64;
    localparam int ALPHABET = 26;

    localparam int SYM_W  = 5;
    localparam int SLOT_W = $clog2(MAX_PAT);
    localparam int CNT_W  = $clog2(MAX_PAT + 1);
    localparam int DIFF_W = $clog2(ALPHABET + 1);

    typedef enum logic [1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_PATTERN = 2'd1,
        MODE_TEXT    = 2'd2,
        MODE_RESTART = 2'd3
    } t_mode;

    typedef struct packed {
        logic             clear_all;
        logic             restart;
        logic             add_pat;
        logic             text_step;
        logic             drop_old;
        logic [SYM_W-1:0] sym;
        logic [SYM_W-1:0] old;
    } t_hist_ctl;

    typedef struct packed {
        logic [ALPHABET-1:0] eq_before;
        logic [ALPHABET-1:0] eq_after;
        logic [ALPHABET-1:0] pat_zero;
    } t_hist_sts;

endpackage

/* rtl/swam_delay_line.sv */
// ----------------------------------------------------------------------------
// swam_delay_line
// Ring of recent text letters, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module swam_delay_line (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [swam_pkg::SLOT_W-1:0] i_waddr,
    input  logic [swam_pkg::SYM_W-1:0]  i_wdata,
    input  logic                        i_re,
    input  logic [swam_pkg::SLOT_W-1:0] i_raddr,
    output logic [swam_pkg::SYM_W-1:0]  o_rdata
);
    import swam_pkg::*;

    logic [SYM_W-1:0] r_mem [MAX_PAT];
    logic [SYM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // write-first on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/swam_hist.sv */
// ----------------------------------------------------------------------------
// swam_hist
// Per-letter lanes holding pattern and window counts and their comparisons.
// ----------------------------------------------------------------------------
module swam_hist (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  swam_pkg::t_hist_ctl   i_ctl,
    output swam_pkg::t_hist_sts   o_sts
);
    import swam_pkg::*;

    logic [CNT_W-1:0] r_pat [ALPHABET];
    logic [CNT_W-1:0] r_win [ALPHABET];
    logic [CNT_W-1:0] n_win [ALPHABET];

    for (genvar k = 0; k < ALPHABET; k++) begin : g_lane
        logic inc;
        logic dec;

        assign inc = i_ctl.text_step && (i_ctl.sym == SYM_W'(k));
        assign dec = i_ctl.text_step && i_ctl.drop_old && (i_ctl.old == SYM_W'(k));
        assign n_win[k] = r_win[k] + CNT_W'(inc) - CNT_W'(dec);
        assign o_sts.eq_before[k] = (r_win[k] == r_pat[k]);
        assign o_sts.eq_after[k]  = (n_win[k] == r_pat[k]);
        assign o_sts.pat_zero[k]  = (r_pat[k] == '0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n || i_ctl.clear_all) begin
                r_pat[k] <= '0;
            end else if (i_ctl.add_pat && (i_ctl.sym == SYM_W'(k))) begin
                r_pat[k] <= r_pat[k] + CNT_W'(1);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n || i_ctl.restart) begin
                r_win[k] <= '0;
            end else if (i_ctl.text_step) begin
                r_win[k] <= n_win[k];
            end
        end
    end

endmodule

/* rtl/sliding_window_anagram_match_top.sv */
// ----------------------------------------------------------------------------
// sliding_window_anagram_match_top
// Streaming anagram detector over a sliding window of text letters.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready) carries a mode and a letter: clear, add a
// pattern letter, feed a text letter, or restart the text. Every request
// gives exactly one result on the output channel (o_valid/i_ready):
// o_match_here, the sticky o_found and the sticky o_pattern_overflow.
// A request sits in the input register while the letter leaving the window is
// read from the delay line, and the histogram update then lands in the result
// register that drives o_valid. Throughput is one request per cycle while the
// receiver does not stall; the delay line read is issued at acceptance.
// When the receiver stalls, the result register holds and one more request
// is taken into the input register; o_ready then drops until i_ready rises.
// Reset clears the pattern, window, counters and flags, leaving the block
// ready with no result pending. The delay line needs no clearing: an entry
// is read only after it has been written since the last text restart.
// ----------------------------------------------------------------------------
module sliding_window_anagram_match_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_mode,
    input  logic [swam_pkg::SYM_W-1:0] i_letter,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_match_here,
    output logic                       o_found,
    output logic                       o_pattern_overflow
);
    import swam_pkg::*;

    logic              r_in_valid;
    t_mode             r_in_mode;
    logic [SYM_W-1:0]  r_in_letter;
    logic              r_out_valid;
    logic              r_match;
    logic              r_found_out;
    logic              r_ovf_out;

    logic [SLOT_W-1:0] r_write_slot, n_write_slot;
    logic [CNT_W-1:0]  r_len, n_len;
    logic [CNT_W-1:0]  r_seen, n_seen;
    logic [DIFF_W-1:0] r_diff, n_diff;
    logic [DIFF_W-1:0] r_nonzero, n_nonzero;
    logic              r_found, n_found;
    logic              r_ovf, n_ovf;

    logic              proc;
    logic              accept;
    logic              sym_ok;
    logic              full;
    logic              hit;
    logic              up_s, dn_s, up_o, dn_o;
    logic [DIFF_W-1:0] diff_step;
    logic [CNT_W-1:0]  seen_step;
    logic [SLOT_W-1:0] rd_slot;
    logic [SYM_W-1:0]  old_letter;
    t_hist_ctl         hist_ctl;
    t_hist_sts         hist_sts;

    assign proc    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || proc;
    assign accept  = i_valid && o_ready;
    assign sym_ok  = (r_in_letter < SYM_W'(ALPHABET));
    assign full    = (r_seen == r_len);

    always_comb begin
        hist_ctl.clear_all = proc && (r_in_mode == MODE_CLEAR);
        hist_ctl.restart   = proc && ((r_in_mode == MODE_CLEAR) || (r_in_mode == MODE_RESTART)
                             || ((r_in_mode == MODE_PATTERN) && sym_ok));
        hist_ctl.add_pat   = proc && (r_in_mode == MODE_PATTERN) && sym_ok
                             && (r_len < CNT_W'(MAX_PAT));
        hist_ctl.text_step = proc && (r_in_mode == MODE_TEXT) && sym_ok && (r_len != '0);
        hist_ctl.drop_old  = full;
        hist_ctl.sym       = r_in_letter;
        hist_ctl.old       = old_letter;
    end

    swam_hist u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (hist_ctl),
        .o_sts   (hist_sts)
    );

    always_comb begin
        up_s = 1'b0;
        dn_s = 1'b0;
        up_o = 1'b0;
        dn_o = 1'b0;
        if (sym_ok) begin
            up_s = hist_sts.eq_before[r_in_letter] && !hist_sts.eq_after[r_in_letter];
            dn_s = !hist_sts.eq_before[r_in_letter] && hist_sts.eq_after[r_in_letter];
        end
        if (full && (old_letter < SYM_W'(ALPHABET))) begin
            up_o = hist_sts.eq_before[old_letter] && !hist_sts.eq_after[old_letter];
            dn_o = !hist_sts.eq_before[old_letter] && hist_sts.eq_after[old_letter];
        end
        diff_step = r_diff + DIFF_W'(up_s) + DIFF_W'(up_o) - DIFF_W'(dn_s) - DIFF_W'(dn_o);
        seen_step = full ? r_seen : r_seen + CNT_W'(1);
    end

    always_comb begin
        hit = proc && (r_in_mode == MODE_TEXT) && sym_ok
              && ((r_len == '0) || ((seen_step == r_len) && (diff_step == '0)));

        n_len        = r_len;
        n_nonzero    = r_nonzero;
        n_ovf        = r_ovf;
        n_seen       = r_seen;
        n_write_slot = r_write_slot;
        n_diff       = r_diff;
        n_found      = r_found;

        if (hist_ctl.clear_all) begin
            n_len     = '0;
            n_nonzero = '0;
            n_ovf     = 1'b0;
        end else if (hist_ctl.add_pat) begin
            n_len = r_len + CNT_W'(1);
            if (hist_sts.pat_zero[r_in_letter]) begin
                n_nonzero = r_nonzero + DIFF_W'(1);
            end
        end else if (proc && (r_in_mode == MODE_PATTERN) && sym_ok) begin
            n_ovf = 1'b1;
        end

        if (hist_ctl.restart) begin
            n_seen       = '0;
            n_write_slot = '0;
            n_diff       = n_nonzero;
            n_found      = 1'b0;
        end else if (hist_ctl.text_step) begin
            n_seen       = seen_step;
            n_write_slot = (r_write_slot == SLOT_W'(MAX_PAT - 1)) ? '0
                           : r_write_slot + SLOT_W'(1);
            n_diff       = diff_step;
        end

        if (hit) begin
            n_found = 1'b1;
        end

        // slot of the letter leaving the window for the next request
        if (CNT_W'(n_write_slot) >= n_len) begin
            rd_slot = SLOT_W'(CNT_W'(n_write_slot) - n_len);
        end else begin
            rd_slot = SLOT_W'(CNT_W'(n_write_slot) + CNT_W'(MAX_PAT) - n_len);
        end
    end

    swam_delay_line u_delay (
        .i_clk   (i_clk),
        .i_we    (hist_ctl.text_step),
        .i_waddr (r_write_slot),
        .i_wdata (r_in_letter),
        .i_re    (accept),
        .i_raddr (rd_slot),
        .o_rdata (old_letter)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_write_slot <= '0;
            r_len        <= '0;
            r_seen       <= '0;
            r_diff       <= '0;
            r_nonzero    <= '0;
            r_found      <= 1'b0;
            r_ovf        <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            r_write_slot <= n_write_slot;
            r_len        <= n_len;
            r_seen       <= n_seen;
            r_diff       <= n_diff;
            r_nonzero    <= n_nonzero;
            r_found      <= n_found;
            r_ovf        <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_mode   <= t_mode'(i_mode);
            r_in_letter <= i_letter;
        end
        if (proc) begin
            r_match     <= hit;
            r_found_out <= n_found;
            r_ovf_out   <= n_ovf;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_match_here       = r_match;
    assign o_found            = r_found_out;
    assign o_pattern_overflow = r_ovf_out;

endmodule

/* rtl/swam_checker.sv */
// ----------------------------------------------------------------------------
// swam_checker
// Port-level checks for the sliding window anagram matcher.
// ----------------------------------------------------------------------------
module swam_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_ready,
    input logic [1:0]                 i_mode,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic                       o_match_here,
    input logic                       o_found,
    input logic                       o_pattern_overflow
);
    import swam_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_match_here) && $stable(o_found)
            && $stable(o_pattern_overflow))
        else $error("result changed while stalled");

    a_match_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_match_here |-> o_found)
        else $error("match without found flag");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("not empty after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("request refused with no result pending");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_mode == MODE_CLEAR) && !o_valid ##1 i_ready
            |=> o_valid && !o_match_here && !o_found && !o_pattern_overflow)
        else $error("clear request gave a nonzero result");

endmodule

bind sliding_window_anagram_match_top swam_checker u_swam_checker (.*);
